### design/ipsp_pkg.sv
// Shared types, codes and constants for the IPS patch stream parser.
package ipsp_pkg;

  localparam int unsigned AddrW  = 24;
  localparam int unsigned LenW   = 16;
  localparam int unsigned TotW   = 25;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QCntW  = 3;

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_FILL   = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_HDR = 2'd1;
  localparam logic [1:0] ST_TRUNC   = 2'd2;

  localparam logic         REG_APPLY_MODE  = 1'b0;
  localparam logic         REG_TARGET_SIZE = 1'b1;

  localparam logic [AddrW-1:0] END_OFFSET = 24'hFFFFFF;
  localparam logic [AddrW-1:0] EOF_OFFSET = 24'h454F46;
  localparam logic [TotW-1:0]  TOT_MAX    = 25'h1FFFFFF;

  typedef struct packed {
    logic [TotW-1:0]  total;
    logic [1:0]       status;
    logic [LenW-1:0]  run_length;
    logic [7:0]       value;
    logic [AddrW-1:0] address;
    logic [1:0]       kind;
  } result_t;

  // "PATCH"
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd1:    b = 8'h41;
      3'd2:    b = 8'h54;
      3'd3:    b = 8'h43;
      3'd4:    b = 8'h48;
      default: b = 8'h50;
    endcase
    return b;
  endfunction

endpackage

### design/ips_patch_stream_parser.sv
// IPS patch stream parser: byte-wide patch parsing into write/fill/reject/done results.
// Results are registered: each goes into the result queue before it is offered on out_*.
// Throughput: one input beat per cycle while in_tready is high; each beat is parsed in a single registered pass.
// Results go through a four-entry queue; input stalls while it holds more than two.
// Reset (rst_n low, synchronous): parser back to the header phase, queue emptied,
// apply mode on, target size zero.
module ips_patch_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] patch_byte
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [23:0] address, [31:24] value, [47:32] run_length,
                                  // [49:48] status, [74:50] total, [79:75] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [24:0] cfg_data
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_OFFSET = 3'd1;
  localparam logic [2:0] PH_LENGTH = 3'd2;
  localparam logic [2:0] PH_COPY   = 3'd3;
  localparam logic [2:0] PH_FILL   = 3'd4;
  localparam logic [2:0] PH_DRAIN  = 3'd5;

  logic                          apply_mode_r;
  logic [ipsp_pkg::TotW-1:0]     target_size_r;

  logic [2:0]                    phase_r, phase_nxt;
  logic [2:0]                    fc_r, fc_nxt;
  logic [ipsp_pkg::AddrW-1:0]    offset_r, offset_nxt;
  logic [ipsp_pkg::LenW-1:0]     length_r, length_nxt;
  logic [ipsp_pkg::TotW-1:0]     waddr_r, waddr_nxt;
  logic [ipsp_pkg::LenW-1:0]     left_r, left_nxt;
  logic                          skip_r, skip_nxt;
  logic [ipsp_pkg::TotW-1:0]     total_r, total_nxt;

  ipsp_pkg::result_t             q_r [ipsp_pkg::QDepth];
  ipsp_pkg::result_t             q_nxt [ipsp_pkg::QDepth];
  logic [ipsp_pkg::QCntW-1:0]    cnt_r, cnt_nxt;

  ipsp_pkg::result_t             res_a, res_b;
  logic                          a_v, b_v;
  logic                          in_fire, out_fire;

  logic [ipsp_pkg::AddrW-1:0]    off_shift;
  logic [ipsp_pkg::LenW-1:0]     len_shift, len_sel, left_dec;
  logic [ipsp_pkg::TotW-1:0]     end_sum, total_inc;
  logic                          over, meas_upd;

  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;
  assign in_tready = (cnt_r <= ipsp_pkg::QCntW'(ipsp_pkg::QDepth - 2));
  assign cfg_ready = 1'b1;

  assign out_tvalid = (cnt_r != '0);
  assign out_tuser  = q_r[0].kind;
  assign out_tdata  = {5'd0, q_r[0].total, q_r[0].status, q_r[0].run_length,
                       q_r[0].value, q_r[0].address};

  assign off_shift = {offset_r[15:0], in_tdata};
  assign len_shift = {length_r[7:0], in_tdata};
  assign len_sel   = (phase_r == PH_LENGTH) ? len_shift : length_r;
  assign end_sum   = {1'b0, offset_r} + {9'd0, len_sel};
  assign over      = end_sum > target_size_r;
  assign meas_upd  = total_r < end_sum;
  assign left_dec  = left_r - 16'd1;
  assign total_inc = (total_r != ipsp_pkg::TOT_MAX) ? total_r + 25'd1 : total_r;

  always_comb begin
    phase_nxt  = phase_r;
    fc_nxt     = fc_r;
    offset_nxt = offset_r;
    length_nxt = length_r;
    waddr_nxt  = waddr_r;
    left_nxt   = left_r;
    skip_nxt   = skip_r;
    total_nxt  = total_r;
    a_v        = 1'b0;
    b_v        = 1'b0;
    res_a      = '0;
    res_b      = '0;
    if (in_fire) begin
      case (phase_r)
        PH_HEADER: begin
          if (in_tdata != ipsp_pkg::magic_byte(fc_r)) begin
            a_v          = 1'b1;
            res_a.kind   = ipsp_pkg::KIND_DONE;
            res_a.status = ipsp_pkg::ST_BAD_HDR;
            phase_nxt    = PH_DRAIN;
          end else if (fc_r >= 3'd4) begin
            phase_nxt = PH_OFFSET;
            fc_nxt    = '0;
          end else begin
            fc_nxt = fc_r + 3'd1;
          end
        end
        PH_OFFSET: begin
          offset_nxt = off_shift;
          if (fc_r >= 3'd2) begin
            fc_nxt = '0;
            if (off_shift == ipsp_pkg::END_OFFSET || off_shift == ipsp_pkg::EOF_OFFSET) begin
              a_v          = 1'b1;
              res_a.kind   = ipsp_pkg::KIND_DONE;
              res_a.status = ipsp_pkg::ST_OK;
              res_a.total  = total_r;
              phase_nxt    = PH_DRAIN;
            end else begin
              phase_nxt  = PH_LENGTH;
              length_nxt = '0;
            end
          end else begin
            fc_nxt = fc_r + 3'd1;
          end
        end
        PH_LENGTH: begin
          length_nxt = len_shift;
          if (fc_r >= 3'd1) begin
            fc_nxt = '0;
            if (len_shift != '0) begin
              if (!apply_mode_r) begin
                if (meas_upd) begin
                  total_nxt = end_sum;
                end
                skip_nxt = 1'b1;
              end else if (over) begin
                a_v              = 1'b1;
                res_a.kind       = ipsp_pkg::KIND_REJECT;
                res_a.address    = offset_r;
                res_a.run_length = len_shift;
                skip_nxt         = 1'b1;
              end else begin
                skip_nxt = 1'b0;
              end
              left_nxt  = len_shift;
              waddr_nxt = {1'b0, offset_r};
              phase_nxt = PH_COPY;
            end else begin
              phase_nxt = PH_FILL;
            end
          end else begin
            fc_nxt = fc_r + 3'd1;
          end
        end
        PH_COPY: begin
          if (!skip_r) begin
            a_v           = 1'b1;
            res_a.kind    = ipsp_pkg::KIND_WRITE;
            res_a.address = waddr_r[ipsp_pkg::AddrW-1:0];
            res_a.value   = in_tdata;
          end
          waddr_nxt = waddr_r + 25'd1;
          left_nxt  = left_dec;
          if (left_dec == '0) begin
            if (!skip_r) begin
              total_nxt = total_inc;
            end
            phase_nxt = PH_OFFSET;
            fc_nxt    = '0;
          end
        end
        PH_FILL: begin
          if (fc_r < 3'd2) begin
            length_nxt = len_shift;
            fc_nxt     = fc_r + 3'd1;
          end else begin
            if (!apply_mode_r) begin
              if (meas_upd) begin
                total_nxt = end_sum;
              end
            end else begin
              a_v              = 1'b1;
              res_a.address    = offset_r;
              res_a.value      = in_tdata;
              res_a.run_length = length_r;
              if (length_r == '0 || over) begin
                res_a.kind = ipsp_pkg::KIND_REJECT;
              end else begin
                res_a.kind = ipsp_pkg::KIND_FILL;
                total_nxt  = total_inc;
              end
            end
            phase_nxt = PH_OFFSET;
            fc_nxt    = '0;
          end
        end
        default: begin
        end
      endcase

      if (in_tlast) begin
        if (phase_r != PH_DRAIN && phase_nxt != PH_DRAIN) begin
          b_v         = 1'b1;
          res_b.kind  = ipsp_pkg::KIND_DONE;
          res_b.total = total_nxt;
          if (phase_nxt == PH_HEADER) begin
            res_b.status = ipsp_pkg::ST_BAD_HDR;
            res_b.total  = '0;
          end else if (phase_nxt == PH_OFFSET && fc_nxt == '0) begin
            res_b.status = ipsp_pkg::ST_OK;
          end else begin
            res_b.status = ipsp_pkg::ST_TRUNC;
          end
        end
        phase_nxt  = PH_HEADER;
        fc_nxt     = '0;
        offset_nxt = '0;
        length_nxt = '0;
        waddr_nxt  = '0;
        left_nxt   = '0;
        skip_nxt   = 1'b0;
        total_nxt  = '0;
      end
    end
  end

  // result queue: head at entry 0, shifts on pop, up to two pushes per beat
  always_comb begin
    logic [ipsp_pkg::QCntW-1:0] base;
    logic                       push0, push1;
    ipsp_pkg::result_t          d0;
    base    = cnt_r - ipsp_pkg::QCntW'(out_fire);
    push0   = a_v || b_v;
    push1   = a_v && b_v;
    d0      = a_v ? res_a : res_b;
    cnt_nxt = base + ipsp_pkg::QCntW'(push0) + ipsp_pkg::QCntW'(push1);
    for (int i = 0; i < ipsp_pkg::QDepth; i++) begin
      if (out_fire && i < ipsp_pkg::QDepth - 1) begin
        q_nxt[i] = q_r[i+1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (push0 && ipsp_pkg::QCntW'(i) == base) begin
        q_nxt[i] = d0;
      end
      if (push1 && ipsp_pkg::QCntW'(i) == base + 3'd1) begin
        q_nxt[i] = res_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      apply_mode_r  <= 1'b1;
      target_size_r <= '0;
      phase_r       <= PH_HEADER;
      fc_r          <= '0;
      offset_r      <= '0;
      length_r      <= '0;
      waddr_r       <= '0;
      left_r        <= '0;
      skip_r        <= 1'b0;
      total_r       <= '0;
      cnt_r         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ipsp_pkg::REG_APPLY_MODE:  apply_mode_r  <= cfg_data[0];
          ipsp_pkg::REG_TARGET_SIZE: target_size_r <= cfg_data;
          default: begin
          end
        endcase
      end
      phase_r  <= phase_nxt;
      fc_r     <= fc_nxt;
      offset_r <= offset_nxt;
      length_r <= length_nxt;
      waddr_r  <= waddr_nxt;
      left_r   <= left_nxt;
      skip_r   <= skip_nxt;
      total_r  <= total_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ipsp_pkg::QDepth; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ipsp_pkg::QCntW'(ipsp_pkg::QDepth))
    else $error("result queue overflow");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> (phase_r == PH_HEADER && fc_r == '0 && total_r == '0))
    else $error("parser not back to header after last beat");

  a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEADER) |-> (fc_r < 3'd5))
    else $error("header count out of range");

  a_copy_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_COPY) |-> (left_r != '0))
    else $error("copy phase with no bytes left");

  a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_OFFSET || phase_r == PH_FILL) |-> (fc_r < 3'd3))
    else $error("field count out of range");

endmodule

### dv/tb_ips_patch_stream_parser.sv
// Testbench for the IPS patch stream parser: random and directed patch files, scoreboarded.
`timescale 1ns / 1ps

module tb_ips_patch_stream_parser;

  localparam int CycleLimit = 300000;
  localparam int HoldCycles = 300;
  localparam int PhaseBeats = 170;
  localparam logic [7:0] PATCH_TAG [0:4] = '{8'h50, 8'h41, 8'h54, 8'h43, 8'h48};

  typedef enum logic [2:0] {
    PS_HEADER, PS_OFFSET, PS_LENGTH, PS_COPY, PS_FILL, PS_DRAIN
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       lst;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [24:0] cfg_data = '0;

  ips_patch_stream_parser dut (.*);

  always #5 clk = ~clk;

  // predictor copy of registers and parser state
  logic         mdl_apply = 1'b1;
  logic [24:0]  mdl_target = '0;
  parse_phase_t ps = PS_HEADER;
  logic [2:0]   fld_cnt = '0;
  logic [23:0]  rec_ofs = '0;
  logic [15:0]  rec_len = '0;
  logic [24:0]  wr_addr = '0;
  logic [15:0]  bytes_left = '0;
  logic         skip_copy = 1'b0;
  logic [24:0]  tally = '0;

  ipsp_pkg::result_t expected_q[$];
  beat_t             beat_q[$];
  logic [7:0]        fbuf[$];

  int errors = 0;
  int cycles = 0;
  int n_beats = 0;
  int n_queued = 0;
  int n_files = 0;
  int n_kind[4] = '{0, 0, 0, 0};
  int send_idle = 0;
  int recv_stall = 0;
  int hold_left = 0;
  logic hold_kick = 1'b0;

  function automatic ipsp_pkg::result_t mk_result(logic [1:0] k, logic [23:0] a,
                                                  logic [7:0] v, logic [15:0] r,
                                                  logic [1:0] s, logic [24:0] t);
    ipsp_pkg::result_t res;
    res.kind = k;
    res.address = a;
    res.value = v;
    res.run_length = r;
    res.status = s;
    res.total = t;
    return res;
  endfunction

  task automatic track_end(input logic [15:0] len);
    logic [24:0] span;
    span = {1'b0, rec_ofs} + {9'd0, len};
    if (tally < span) tally = span;
  endtask

  task automatic count_record();
    if (tally != ipsp_pkg::TOT_MAX) tally = tally + 25'd1;
  endtask

  task automatic parse_beat(input logic [7:0] b, input logic lst);
    logic        drained;
    logic [24:0] span;
    logic [1:0]  st;
    logic [24:0] tot;
    drained = (ps == PS_DRAIN);
    case (ps)
      PS_HEADER: begin
        if (b != PATCH_TAG[fld_cnt]) begin
          expected_q.push_back(mk_result(ipsp_pkg::KIND_DONE, '0, '0, '0,
                                         ipsp_pkg::ST_BAD_HDR, '0));
          ps = PS_DRAIN;
        end else if (fld_cnt == 3'd4) begin
          ps = PS_OFFSET;
          fld_cnt = '0;
        end else begin
          fld_cnt = fld_cnt + 3'd1;
        end
      end
      PS_OFFSET: begin
        rec_ofs = {rec_ofs[15:0], b};
        fld_cnt = fld_cnt + 3'd1;
        if (fld_cnt == 3'd3) begin
          fld_cnt = '0;
          if (rec_ofs == ipsp_pkg::END_OFFSET || rec_ofs == ipsp_pkg::EOF_OFFSET) begin
            expected_q.push_back(mk_result(ipsp_pkg::KIND_DONE, '0, '0, '0,
                                           ipsp_pkg::ST_OK, tally));
            ps = PS_DRAIN;
          end else begin
            ps = PS_LENGTH;
            rec_len = '0;
          end
        end
      end
      PS_LENGTH: begin
        rec_len = {rec_len[7:0], b};
        fld_cnt = fld_cnt + 3'd1;
        if (fld_cnt == 3'd2) begin
          fld_cnt = '0;
          if (rec_len != 0) begin
            span = {1'b0, rec_ofs} + {9'd0, rec_len};
            if (!mdl_apply) begin
              track_end(rec_len);
              skip_copy = 1'b1;
            end else if (span > mdl_target) begin
              expected_q.push_back(mk_result(ipsp_pkg::KIND_REJECT, rec_ofs, '0, rec_len,
                                             ipsp_pkg::ST_OK, '0));
              skip_copy = 1'b1;
            end else begin
              skip_copy = 1'b0;
            end
            bytes_left = rec_len;
            wr_addr = {1'b0, rec_ofs};
            ps = PS_COPY;
          end else begin
            ps = PS_FILL;
          end
        end
      end
      PS_COPY: begin
        if (!skip_copy)
          expected_q.push_back(mk_result(ipsp_pkg::KIND_WRITE, wr_addr[23:0], b, '0,
                                         ipsp_pkg::ST_OK, '0));
        wr_addr = wr_addr + 25'd1;
        bytes_left = bytes_left - 16'd1;
        if (bytes_left == 0) begin
          if (!skip_copy) count_record();
          ps = PS_OFFSET;
          fld_cnt = '0;
        end
      end
      PS_FILL: begin
        if (fld_cnt < 3'd2) begin
          rec_len = {rec_len[7:0], b};
          fld_cnt = fld_cnt + 3'd1;
        end else begin
          span = {1'b0, rec_ofs} + {9'd0, rec_len};
          if (!mdl_apply) begin
            track_end(rec_len);
          end else if (rec_len == 0 || span > mdl_target) begin
            expected_q.push_back(mk_result(ipsp_pkg::KIND_REJECT, rec_ofs, b, rec_len,
                                           ipsp_pkg::ST_OK, '0));
          end else begin
            expected_q.push_back(mk_result(ipsp_pkg::KIND_FILL, rec_ofs, b, rec_len,
                                           ipsp_pkg::ST_OK, '0));
            count_record();
          end
          ps = PS_OFFSET;
          fld_cnt = '0;
        end
      end
      default: ;
    endcase
    if (lst) begin
      if (!drained && ps != PS_DRAIN) begin
        tot = tally;
        if (ps == PS_HEADER) begin
          st = ipsp_pkg::ST_BAD_HDR;
          tot = '0;
        end else if (ps == PS_OFFSET && fld_cnt == 0) begin
          st = ipsp_pkg::ST_OK;
        end else begin
          st = ipsp_pkg::ST_TRUNC;
        end
        expected_q.push_back(mk_result(ipsp_pkg::KIND_DONE, '0, '0, '0, st, tot));
      end
      ps = PS_HEADER;
      fld_cnt = '0;
      rec_ofs = '0;
      rec_len = '0;
      wr_addr = '0;
      bytes_left = '0;
      skip_copy = 1'b0;
      tally = '0;
    end
  endtask

  // input driver
  always @(posedge clk) begin
    beat_t nxt;
    if (in_tvalid && in_tready) begin
      parse_beat(in_tdata, in_tlast);
      n_beats++;
    end
    if (in_tvalid && !in_tready) begin
    end else if (beat_q.size() != 0 && $urandom_range(99) >= send_idle) begin
      nxt = beat_q.pop_front();
      in_tvalid <= 1'b1;
      in_tdata <= nxt.data;
      in_tlast <= nxt.lst;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [24:0] want, input logic [24:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    ipsp_pkg::result_t want;
    if (out_tvalid && out_tready) begin
      n_kind[out_tuser]++;
      if (expected_q.size() == 0) begin
        $error("unexpected result: kind %0d addr 0x%0h", out_tuser, out_tdata[23:0]);
        errors++;
      end else begin
        want = expected_q.pop_front();
        check_field("kind", 25'(want.kind), 25'(out_tuser));
        check_field("address", 25'(want.address), 25'(out_tdata[23:0]));
        check_field("value", 25'(want.value), 25'(out_tdata[31:24]));
        check_field("run_length", 25'(want.run_length), 25'(out_tdata[47:32]));
        check_field("status", 25'(want.status), 25'(out_tdata[49:48]));
        check_field("total", want.total, out_tdata[74:50]);
        check_field("pad", '0, 25'(out_tdata[79:75]));
      end
    end
    out_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall);
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_kick) hold_left <= HoldCycles;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb_ips_patch_stream_parser: FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [24:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == ipsp_pkg::REG_APPLY_MODE) mdl_apply = val[0];
    else mdl_target = val;
  endtask

  task automatic settle();
    do @(posedge clk);
    while (beat_q.size() != 0 || in_tvalid || expected_q.size() != 0 || hold_left != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic add_word(input int unsigned v, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) fbuf.push_back(8'(v >> (8 * i)));
  endtask

  task automatic add_hdr();
    for (int i = 0; i < 5; i++) fbuf.push_back(PATCH_TAG[i]);
  endtask

  task automatic add_copy(input logic [23:0] ofs, input int len);
    add_word(32'(ofs), 3);
    add_word(len, 2);
    repeat (len) fbuf.push_back(8'($urandom_range(255)));
  endtask

  task automatic add_fill(input logic [23:0] ofs, input logic [15:0] run, input logic [7:0] val);
    add_word(32'(ofs), 3);
    add_word(0, 2);
    add_word(32'(run), 2);
    fbuf.push_back(val);
  endtask

  task automatic ship(input int cut, input logic with_last);
    beat_t bt;
    for (int i = 0; i < cut; i++) begin
      bt.data = fbuf[i];
      bt.lst = with_last && (i == cut - 1);
      beat_q.push_back(bt);
    end
    n_queued += cut;
    if (with_last) n_files++;
    fbuf.delete();
  endtask

  function automatic logic [23:0] pick_ofs();
    int r;
    r = $urandom_range(9);
    if (r < 6) return 24'($urandom_range(700));
    if (r < 8) return 24'($urandom);
    return ipsp_pkg::END_OFFSET - 24'($urandom_range(1, 64));
  endfunction

  task automatic rand_file();
    int nrec;
    int len;
    int cut;
    int r;
    logic [15:0] run;
    add_hdr();
    if ($urandom_range(99) < 4) fbuf[$urandom_range(4)] = 8'($urandom_range(255));
    nrec = $urandom_range(5);
    repeat (nrec) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      if ($urandom_range(99) < 55) begin
        add_copy(pick_ofs(), len);
      end else begin
        r = $urandom_range(9);
        run = (r == 0) ? 16'd0 : (r < 4) ? 16'($urandom_range(65535))
                                          : 16'($urandom_range(1, 300));
        add_fill(pick_ofs(), run, 8'($urandom_range(255)));
      end
    end
    r = $urandom_range(9);
    if (r < 7) begin
      add_word(32'((r < 4) ? ipsp_pkg::END_OFFSET : ipsp_pkg::EOF_OFFSET), 3);
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(1, 4)) fbuf.push_back(8'($urandom_range(255)));
    end
    cut = fbuf.size();
    if ($urandom_range(99) < 12) cut = $urandom_range(1, fbuf.size());
    ship(cut, 1'b1);
  endtask

  task automatic run_phase(input logic apply, input logic [24:0] target, input int sidle,
                           input int rstall, input logic pressure);
    int stop;
    write_reg(ipsp_pkg::REG_APPLY_MODE, 25'(apply));
    write_reg(ipsp_pkg::REG_TARGET_SIZE, target);
    @(posedge clk);
    send_idle <= sidle;
    recv_stall <= rstall;
    hold_kick <= pressure;
    @(posedge clk);
    hold_kick <= 1'b0;
    stop = n_queued + PhaseBeats;
    while (n_queued < stop) rand_file();
    settle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    write_reg(ipsp_pkg::REG_APPLY_MODE, 25'd1);
    write_reg(ipsp_pkg::REG_TARGET_SIZE, ipsp_pkg::TOT_MAX);

    // copy across the 24-bit boundary, zero-length fill, "EOF" marker
    add_hdr();
    fbuf.push_back(8'hFF); fbuf.push_back(8'hFF); fbuf.push_back(8'hFE);
    add_word(3, 2);
    fbuf.push_back(8'h00); fbuf.push_back(8'hFF); fbuf.push_back(8'h5A);
    add_fill(24'h000000, 16'd0, 8'hAA);
    add_word(32'(ipsp_pkg::EOF_OFFSET), 3);
    ship(fbuf.size(), 1'b1);
    // header cut short, then header mismatch on the last beat
    fbuf.push_back(8'h50); fbuf.push_back(8'h41);
    ship(2, 1'b1);
    fbuf.push_back(8'h50); fbuf.push_back(8'h58);
    ship(2, 1'b1);
    settle();

    run_phase(1'b1, 25'd600, 0, 0, 1'b0);

    // switch to measure mode in the middle of a file; the count carries over
    add_hdr();
    add_fill(24'd100, 16'd10, 8'h3C);
    ship(fbuf.size(), 1'b0);
    settle();
    write_reg(ipsp_pkg::REG_APPLY_MODE, 25'd0);
    add_copy(24'd50, 4);
    add_word(32'(ipsp_pkg::END_OFFSET), 3);
    ship(fbuf.size(), 1'b1);
    settle();

    run_phase(1'b0, 25'd600, 51, 0, 1'b0);
    run_phase(1'b1, 25'd0, 0, 51, 1'b0);
    run_phase(1'b1, ipsp_pkg::TOT_MAX, 13, 13, 1'b0);
    run_phase(1'b1, ipsp_pkg::TOT_MAX, 0, 0, 1'b1);
    run_phase(1'b0, ipsp_pkg::TOT_MAX, 13, 13, 1'b0);

    $display("run: %0d beats in %0d patch files, apply and measure modes, target 0 to max",
             n_beats, n_files);
    $display("results: %0d writes, %0d fills, %0d rejects, %0d dones, %0d mismatches",
             n_kind[ipsp_pkg::KIND_WRITE], n_kind[ipsp_pkg::KIND_FILL],
             n_kind[ipsp_pkg::KIND_REJECT], n_kind[ipsp_pkg::KIND_DONE], errors);
    if (errors == 0) begin
      $display("tb_ips_patch_stream_parser: PASS");
    end else begin
      $display("tb_ips_patch_stream_parser: FAIL");
    end
    $finish;
  end

endmodule

### ips_patch_stream_parser.f
design/ipsp_pkg.sv
design/ips_patch_stream_parser.sv
dv/tb_ips_patch_stream_parser.sv
